// ===== rtl/gpiob_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpiob_pkg: shared types and constants of the GPIO bank
// Command and register select codes, bus data width, default bank width.
// ----------------------------------------------------------------------------
package gpiob_pkg;

   // Bus and pad data width, one bit per pin
   localparam int DATA_WIDTH = 32;

   // Default number of pins in the bank
   localparam int BANK_WIDTH_DEFAULT = 32;

   // Request command codes
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   // Register select codes
   typedef enum logic [2:0] {
      REG_OUT      = 3'd0,
      REG_IN       = 3'd1,
      REG_STATUS   = 3'd2,
      REG_CLEAR    = 3'd3,
      REG_ENABLE   = 3'd4,
      REG_EDGE     = 3'd5,
      REG_POLARITY = 3'd6,
      REG_OE       = 3'd7
   } reg_sel_type;

endpackage : gpiob_pkg
`default_nettype wire

// ===== rtl/gpio_bank_with_interrupt_detect.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_bank_with_interrupt_detect: GPIO bank with edge/level interrupts
// Register block for one bank of pins: output, input sample, interrupt
// status, clear, enable, edge select, polarity and output enable.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  cmd, reg_sel, write_data,
//                                            pin_levels
//   rsp      out        rsp_valid/rsp_ready  read_data, pad_drive,
//                                            pad_enable, irq_pending
//
// One request is taken per clock unless stalled; its response is registered.
// The bank registers update at the edge that accepts the request, and the
// response register captures the updated view at the same edge.
// A stalled response holds its register; a new request is still taken
// whenever the response is consumed in the same cycle.
// Reset clears every bank register and drops rsp_valid.
// ----------------------------------------------------------------------------
module gpio_bank_with_interrupt_detect #(
   parameter int BANK_WIDTH = gpiob_pkg::BANK_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [2:0]                      req_reg_sel,
   input  wire logic [gpiob_pkg::DATA_WIDTH-1:0] req_write_data,
   input  wire logic [gpiob_pkg::DATA_WIDTH-1:0] req_pin_levels,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [gpiob_pkg::DATA_WIDTH-1:0] rsp_read_data,
   output logic      [gpiob_pkg::DATA_WIDTH-1:0] rsp_pad_drive,
   output logic      [gpiob_pkg::DATA_WIDTH-1:0] rsp_pad_enable,
   output logic                                 rsp_irq_pending
);

   import gpiob_pkg::*;

   // Bank registers
   logic [BANK_WIDTH-1:0] out_ff,      out_in;
   logic [BANK_WIDTH-1:0] oe_ff,       oe_in;
   logic [BANK_WIDTH-1:0] edge_ff,     edge_in;
   logic [BANK_WIDTH-1:0] polarity_ff, polarity_in;
   logic [BANK_WIDTH-1:0] enable_ff,   enable_in;
   logic [BANK_WIDTH-1:0] status_ff,   status_in;
   logic [BANK_WIDTH-1:0] last_ff,     last_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] read_data_ff, read_data_in;
   logic [DATA_WIDTH-1:0] pad_drive_ff;
   logic [DATA_WIDTH-1:0] pad_enable_ff;
   logic                  irq_ff;

   logic                  req_fire;
   logic                  rsp_fire;
   cmd_type               cmd;
   reg_sel_type           sel;
   logic [BANK_WIDTH-1:0] wdata;
   logic [BANK_WIDTH-1:0] pins;
   logic [BANK_WIDTH-1:0] hit;
   logic [BANK_WIDTH-1:0] rd_value;

   assign cmd   = cmd_type'(req_cmd);
   assign sel   = reg_sel_type'(req_reg_sel);
   assign wdata = req_write_data[BANK_WIDTH-1:0];
   assign pins  = req_pin_levels[BANK_WIDTH-1:0];

   // Take a request whenever the response slot is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // Detect pin events against the previous sample
   gpiob_detect #(
      .BANK_WIDTH (BANK_WIDTH)
   ) u_detect (
      .pins      (pins),
      .last_pins (last_ff),
      .polarity  (polarity_ff),
      .edge_sel  (edge_ff),
      .hit       (hit)
   );

   // Select the register for a bus read
   always_comb begin
      case (sel)
         REG_OUT:      rd_value = out_ff;
         REG_IN:       rd_value = last_ff;
         REG_STATUS:   rd_value = status_ff;
         REG_CLEAR:    rd_value = '0;
         REG_ENABLE:   rd_value = enable_ff;
         REG_EDGE:     rd_value = edge_ff;
         REG_POLARITY: rd_value = polarity_ff;
         REG_OE:       rd_value = oe_ff;
         default:      rd_value = '0;
      endcase
   end

   // Compute the next bank state and read data for this request
   always_comb begin
      out_in       = out_ff;
      oe_in        = oe_ff;
      edge_in      = edge_ff;
      polarity_in  = polarity_ff;
      enable_in    = enable_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      read_data_in = '0;
      case (cmd)
         CMD_TICK: begin
            status_in = status_ff | hit;
            last_in   = pins;
         end
         CMD_READ: begin
            read_data_in = DATA_WIDTH'(rd_value);
         end
         CMD_WRITE: begin
            case (sel)
               REG_OUT:      out_in      = wdata;
               REG_CLEAR:    status_in   = status_ff & ~wdata;
               REG_ENABLE:   enable_in   = wdata;
               REG_EDGE:     edge_in     = wdata;
               REG_POLARITY: polarity_in = wdata;
               REG_OE:       oe_in       = wdata;
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Hold the response until taken, load a new one on each request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Bank state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff       <= '0;
         oe_ff        <= '0;
         edge_ff      <= '0;
         polarity_ff  <= '0;
         enable_ff    <= '0;
         status_ff    <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            out_ff      <= out_in;
            oe_ff       <= oe_in;
            edge_ff     <= edge_in;
            polarity_ff <= polarity_in;
            enable_ff   <= enable_in;
            status_ff   <= status_in;
            last_ff     <= last_in;
         end
      end
   end

   // Response payload, captured from the updated state
   always_ff @(posedge clock) begin
      if (req_fire) begin
         read_data_ff  <= read_data_in;
         pad_drive_ff  <= DATA_WIDTH'(out_in);
         pad_enable_ff <= DATA_WIDTH'(oe_in);
         irq_ff        <= |(status_in & enable_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = read_data_ff;
   assign rsp_pad_drive   = pad_drive_ff;
   assign rsp_pad_enable  = pad_enable_ff;
   assign rsp_irq_pending = irq_ff;

`ifndef SYNTHESIS
   // Interrupt flag matches the bank state it was captured with
   a_irq_matches_state: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_irq_pending == (|(status_ff & enable_ff)))
      else $error("irq_pending does not match status and enable");

   // A waiting response always shows the current pad registers
   a_pads_track_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pad_drive == DATA_WIDTH'(out_ff))
                 && (rsp_pad_enable == DATA_WIDTH'(oe_ff)))
      else $error("pad outputs diverge from bank registers");

   // Only a read returns nonzero data
   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (cmd != CMD_READ)) |=> rsp_read_data == '0)
      else $error("read data nonzero on a non-read request");

   // Status bits drop only through a clear write
   a_status_sticky: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && (cmd == CMD_WRITE) && (sel == REG_CLEAR))
      |=> (status_ff & $past(status_ff)) == $past(status_ff))
      else $error("status bit cleared without a clear write");
`endif

endmodule : gpio_bank_with_interrupt_detect
`default_nettype wire

// ===== rtl/gpiob_detect.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gpiob_detect: per-pin interrupt event detection
// Compares a new pad sample with the previous one and flags the pins whose
// edge or level condition is met under their edge select and polarity bits.
// ----------------------------------------------------------------------------
module gpiob_detect #(
   parameter int BANK_WIDTH = gpiob_pkg::BANK_WIDTH_DEFAULT
) (
   input  wire logic [BANK_WIDTH-1:0] pins,
   input  wire logic [BANK_WIDTH-1:0] last_pins,
   input  wire logic [BANK_WIDTH-1:0] polarity,
   input  wire logic [BANK_WIDTH-1:0] edge_sel,
   output logic      [BANK_WIDTH-1:0] hit
);

   logic [BANK_WIDTH-1:0] rise;
   logic [BANK_WIDTH-1:0] fall;
   logic [BANK_WIDTH-1:0] edge_hit;
   logic [BANK_WIDTH-1:0] level_hit;

   // Find transitions against the previous sample
   assign rise = pins & ~last_pins;
   assign fall = ~pins & last_pins;

   // Polarity 1 picks rising edge or high level, 0 picks falling or low
   assign edge_hit  = (rise & polarity) | (fall & ~polarity);
   assign level_hit = ~(pins ^ polarity);

   // Select edge or level mode per pin
   assign hit = (edge_hit & edge_sel) | (level_hit & ~edge_sel);

endmodule : gpiob_detect
`default_nettype wire
